@@ design/ptpp_pkg.sv @@
// Shared constants, codes and tables of the point-to-polyline projection block.
package ptpp_pkg;

    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_COORD_BITS   = 24;

    localparam int TFRAC    = 16;
    localparam int T_W      = TFRAC + 1;
    localparam int MUL_W    = 32;
    localparam int PROD_W   = 64;
    localparam int ZW       = 28;
    localparam int CORDIC_N = 20;
    localparam int ANG_SUB  = 12;
    localparam int CORDIC_GAIN_SHIFT = 20;

    localparam logic signed [ZW-1:0] DEG90_SUB = ZW'(23592960);
    localparam logic signed [16:0]   FULL_TURN = 17'sd23040;
    localparam logic signed [16:0]   HALF_TURN = 17'sd11520;
    localparam logic [24:0]          DIST_MAX  = 25'h1FFFFFF;
    localparam logic [31:0]          ALONG_MAX = 32'hFFFFFFFF;

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_SHORT = 2'd1;
    localparam logic [1:0] STAT_OVF   = 2'd2;
    localparam logic [1:0] STAT_NOSEG = 2'd3;

    // atan(2^-i) in 1/262144 degree
    function automatic logic signed [ZW-1:0] atan_step(input logic [4:0] i);
        logic signed [ZW-1:0] a;
        case (i)
            5'd0:    a = ZW'(11796480);
            5'd1:    a = ZW'(6963869);
            5'd2:    a = ZW'(3679517);
            5'd3:    a = ZW'(1867780);
            5'd4:    a = ZW'(937515);
            5'd5:    a = ZW'(469214);
            5'd6:    a = ZW'(234664);
            5'd7:    a = ZW'(117339);
            5'd8:    a = ZW'(58671);
            5'd9:    a = ZW'(29335);
            5'd10:   a = ZW'(14668);
            5'd11:   a = ZW'(7334);
            5'd12:   a = ZW'(3667);
            5'd13:   a = ZW'(1833);
            5'd14:   a = ZW'(917);
            5'd15:   a = ZW'(458);
            5'd16:   a = ZW'(229);
            5'd17:   a = ZW'(115);
            5'd18:   a = ZW'(57);
            5'd19:   a = ZW'(29);
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

@@ design/ptpp_if.sv @@
// Request and response channel interfaces of the point-to-polyline projection block.
interface ptpp_req_if import ptpp_pkg::*; #(
    parameter int COORD_BITS = DEF_COORD_BITS
) ();
    logic                         valid;
    logic                         ready;
    logic [1:0]                   action;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [15:0]           object_heading;

    modport source (output valid, action, point_x, point_y, object_heading, input ready);
    modport sink   (input valid, action, point_x, point_y, object_heading, output ready);
endinterface

interface ptpp_rsp_if import ptpp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [24:0]        distance;
    logic [31:0]        along_path;
    logic signed [14:0] track_heading;
    logic signed [14:0] heading_offset;

    modport source (output valid, status, distance, along_path, track_heading, heading_offset,
                    input ready);
    modport sink   (input valid, status, distance, along_path, track_heading, heading_offset,
                    output ready);
endinterface

@@ design/ptpp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ptpp_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ design/point_to_polyline_projection.sv @@
// Point-to-polyline projection: path table, per-segment projection and nearest-segment result.
//
// The block holds a path of up to MAX_VERTICES vertices in a RAM, built by clear and append
// transfers. A query transfer walks every segment in order on one sequencer that shares a
// single 32x32 multiplier, a one-bit-per-cycle divider for the projection parameter, a
// one-bit-per-cycle square root (used for segment length and for the final distance) and a
// 20-step CORDIC for the heading. A segment needs the divide only when the projection falls
// inside it, and the along-path part and the CORDIC only when it becomes the new nearest one;
// a zero-length segment skips all of these and the root. After the last segment the final
// root gives the distance. The input is not ready during a query; clear and append are
// accepted while a finished result still waits in the output register.
// Status: 1 for fewer than two vertices, 3 when every segment has zero length (distance then
// saturates), 2 when an append was dropped on a full table since the last clear, else 0.
module point_to_polyline_projection import ptpp_pkg::*; #(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int COORD_BITS   = DEF_COORD_BITS
) (
    input logic        clk,
    input logic        rst_n,
    ptpp_req_if.sink   req,
    ptpp_rsp_if.source rsp
);
    localparam int CE   = (COORD_BITS < 30) ? COORD_BITS : 30;  // stored coordinate width
    localparam int DW   = CE + 1;                               // difference width
    localparam int CW   = CE + 24;                              // CORDIC datapath width
    localparam int AW   = $clog2(MAX_VERTICES);
    localparam int CNTW = $clog2(MAX_VERTICES + 1);
    localparam int LIM  = 2 ** (CE - 1);
    localparam logic signed [COORD_BITS-1:0] LIM_HI = COORD_BITS'(LIM - 1);
    localparam logic signed [COORD_BITS-1:0] LIM_LO = COORD_BITS'(-LIM);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RDW   = 4'd1;
    localparam logic [3:0] S_RDL   = 4'd2;
    localparam logic [3:0] S_DOT   = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_PROJ  = 4'd5;
    localparam logic [3:0] S_SQRT  = 4'd6;
    localparam logic [3:0] S_SQRTR = 4'd7;
    localparam logic [3:0] S_PART  = 4'd8;
    localparam logic [3:0] S_CORD  = 4'd9;
    localparam logic [3:0] S_CEND  = 4'd10;
    localparam logic [3:0] S_NEXT  = 4'd11;
    localparam logic [3:0] S_FINAL = 4'd12;
    localparam logic [3:0] S_EMIT  = 4'd13;

    // round half away from zero, divide by 2^16
    function automatic logic signed [PROD_W-1:0] rshr16(input logic signed [PROD_W-1:0] v);
        logic [PROD_W-1:0] mag;
        logic [PROD_W-1:0] r;
        mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
        r   = (mag + (PROD_W'(1) << (TFRAC - 1))) >> TFRAC;
        return v[PROD_W-1] ? -$signed(r) : $signed(r);
    endfunction

    // truncated modulo of a full turn, then fold into half a turn
    function automatic logic signed [14:0] wrap_angle(input logic signed [16:0] d);
        logic signed [16:0] r;
        if (d >= FULL_TURN)
            r = d - FULL_TURN;
        else if (d <= -FULL_TURN)
            r = d + FULL_TURN;
        else
            r = d;
        if (r > HALF_TURN)
            r = r - FULL_TURN;
        else if (r < -HALF_TURN)
            r = r + FULL_TURN;
        return r[14:0];
    endfunction

    // control state
    logic [3:0]      state_reg, state_next;
    logic [4:0]      cnt_reg, cnt_next;
    logic            first_reg, first_next;
    logic            found_reg, found_next;
    logic            final_reg, final_next;
    logic            ovf_reg, ovf_next;
    logic            rsp_valid_reg, rsp_valid_next;
    logic [CNTW-1:0] vcount_reg, vcount_next;
    logic [CNTW-1:0] vidx_reg, vidx_next;

    // datapath
    logic signed [CE-1:0]     px_reg, px_next, py_reg, py_next;
    logic signed [15:0]       obj_reg, obj_next;
    logic signed [CE-1:0]     x0_reg, x0_next, y0_reg, y0_next;
    logic signed [CE-1:0]     xe_reg, xe_next, ye_reg, ye_next;
    logic signed [DW-1:0]     vx_reg, vx_next, vy_reg, vy_next;
    logic signed [DW-1:0]     wx_reg, wx_next, wy_reg, wy_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0]        len2_reg, len2_next;
    logic signed [PROD_W-1:0] dot_reg, dot_next;
    logic [T_W-1:0]           t_reg, t_next;
    logic [PROD_W-1:0]        rem_reg, rem_next;
    logic signed [MUL_W-1:0]  dx_reg, dx_next, dy_reg, dy_next;
    logic [PROD_W-1:0]        d2_reg, d2_next;
    logic [PROD_W-1:0]        sqn_reg, sqn_next, sqres_reg, sqres_next, sqbit_reg, sqbit_next;
    logic [31:0]              seg_reg, seg_next;
    logic [31:0]              prefix_reg, prefix_next;
    logic [31:0]              part_reg, part_next;
    logic [PROD_W-1:0]        best_d2_reg, best_d2_next;
    logic [31:0]              best_s_reg, best_s_next;
    logic signed [14:0]       best_h_reg, best_h_next;
    logic signed [CW-1:0]     cx_reg, cx_next, cy_reg, cy_next;
    logic signed [ZW-1:0]     cz_reg, cz_next;

    logic [1:0]         res_status_reg, res_status_next;
    logic [24:0]        res_dist_reg, res_dist_next;
    logic [31:0]        res_along_reg, res_along_next;
    logic signed [14:0] res_ph_reg, res_ph_next;
    logic signed [14:0] res_ho_reg, res_ho_next;
    logic [1:0]         out_status_reg;
    logic [24:0]        out_dist_reg;
    logic [31:0]        out_along_reg;
    logic signed [14:0] out_ph_reg;
    logic signed [14:0] out_ho_reg;

    // shared multiplier
    logic signed [MUL_W-1:0] mul_a, mul_b;

    // input saturation and RAM
    logic signed [COORD_BITS-1:0] sx_wide, sy_wide;
    logic signed [CE-1:0]         sx, sy;
    logic                         accept, ram_we, out_load;
    logic [2*CE-1:0]              rdata;
    logic signed [CE-1:0]         rd_x, rd_y;

    // misc combinational helpers
    logic [PROD_W-1:0]        rem2, sq_try, sq_rnd;
    logic [32:0]              sum33;
    logic signed [CW-1:0]     cxs, cys, ivx, ivy;
    logic [ZW-1:0]            zmag, zr;
    logic [CNTW:0]            vidx_inc;

    assign accept   = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        sx_wide = req.point_x;
        sy_wide = req.point_y;
        if (req.point_x > LIM_HI)
            sx_wide = LIM_HI;
        else if (req.point_x < LIM_LO)
            sx_wide = LIM_LO;
        if (req.point_y > LIM_HI)
            sy_wide = LIM_HI;
        else if (req.point_y < LIM_LO)
            sy_wide = LIM_LO;
        sx = sx_wide[CE-1:0];
        sy = sy_wide[CE-1:0];
    end

    assign ram_we = accept && (req.action == ACT_APPEND)
                    && (vcount_reg < CNTW'(MAX_VERTICES));

    ptpp_ram #(
        .WIDTH (2 * CE),
        .DEPTH (MAX_VERTICES)
    ) u_vtx_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (vcount_reg[AW-1:0]),
        .wdata ({sx, sy}),
        .raddr (vidx_reg[AW-1:0]),
        .rdata (rdata)
    );

    assign rd_x = rdata[2*CE-1:CE];
    assign rd_y = rdata[CE-1:0];

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_DOT:
            begin
                case (cnt_reg)
                    5'd0:    begin mul_a = MUL_W'(vx_reg); mul_b = MUL_W'(vx_reg); end
                    5'd1:    begin mul_a = MUL_W'(vy_reg); mul_b = MUL_W'(vy_reg); end
                    5'd2:    begin mul_a = MUL_W'(wx_reg); mul_b = MUL_W'(vx_reg); end
                    5'd3:    begin mul_a = MUL_W'(wy_reg); mul_b = MUL_W'(vy_reg); end
                    default: ;
                endcase
            end
            S_PROJ:
            begin
                case (cnt_reg)
                    5'd0:    begin mul_a = $signed(MUL_W'(t_reg)); mul_b = MUL_W'(vx_reg); end
                    5'd1:    begin mul_a = $signed(MUL_W'(t_reg)); mul_b = MUL_W'(vy_reg); end
                    5'd2:    begin mul_a = dx_reg; mul_b = dx_reg; end
                    5'd3:    begin mul_a = dy_reg; mul_b = dy_reg; end
                    default: ;
                endcase
            end
            S_PART:
            begin
                mul_a = $signed(MUL_W'(t_reg));
                mul_b = $signed(seg_reg);
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        first_next      = first_reg;
        found_next      = found_reg;
        final_next      = final_reg;
        ovf_next        = ovf_reg;
        rsp_valid_next  = rsp_valid_reg;
        vcount_next     = vcount_reg;
        vidx_next       = vidx_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        obj_next        = obj_reg;
        x0_next         = x0_reg;
        y0_next         = y0_reg;
        xe_next         = xe_reg;
        ye_next         = ye_reg;
        vx_next         = vx_reg;
        vy_next         = vy_reg;
        wx_next         = wx_reg;
        wy_next         = wy_reg;
        len2_next       = len2_reg;
        dot_next        = dot_reg;
        t_next          = t_reg;
        rem_next        = rem_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        d2_next         = d2_reg;
        sqn_next        = sqn_reg;
        sqres_next      = sqres_reg;
        sqbit_next      = sqbit_reg;
        seg_next        = seg_reg;
        prefix_next     = prefix_reg;
        part_next       = part_reg;
        best_d2_next    = best_d2_reg;
        best_s_next     = best_s_reg;
        best_h_next     = best_h_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        cz_next         = cz_reg;
        res_status_next = res_status_reg;
        res_dist_next   = res_dist_reg;
        res_along_next  = res_along_reg;
        res_ph_next     = res_ph_reg;
        res_ho_next     = res_ho_reg;
        out_load        = 1'b0;

        rem2     = rem_reg << 1;
        sq_try   = sqres_reg + sqbit_reg;
        sq_rnd   = (sqn_reg > sqres_reg) ? sqres_reg + PROD_W'(1) : sqres_reg;
        sum33    = '0;
        cxs      = cx_reg >>> cnt_reg;
        cys      = cy_reg >>> cnt_reg;
        ivx      = CW'(vx_reg);
        ivy      = CW'(vy_reg);
        zmag     = cz_reg[ZW-1] ? ZW'(-cz_reg) : ZW'(cz_reg);
        zr       = (zmag + (ZW'(1) << (ANG_SUB - 1))) >> ANG_SUB;
        vidx_inc = {1'b0, vidx_reg} + (CNTW+1)'(1);

        if (rsp_valid_reg && rsp.ready)
            rsp_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.action)
                        ACT_CLEAR:
                        begin
                            vcount_next = '0;
                            ovf_next    = 1'b0;
                        end
                        ACT_APPEND:
                        begin
                            if (vcount_reg < CNTW'(MAX_VERTICES))
                                vcount_next = vcount_reg + CNTW'(1);
                            else
                                ovf_next = 1'b1;
                        end
                        ACT_QUERY:
                        begin
                            px_next  = sx;
                            py_next  = sy;
                            obj_next = req.object_heading;
                            if (vcount_reg < CNTW'(2))
                            begin
                                res_status_next = STAT_SHORT;
                                res_dist_next   = '0;
                                res_along_next  = '0;
                                res_ph_next     = '0;
                                res_ho_next     = '0;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                vidx_next   = '0;
                                first_next  = 1'b1;
                                found_next  = 1'b0;
                                prefix_next = '0;
                                state_next  = S_RDW;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RDW:
            begin
                state_next = S_RDL;
            end
            S_RDL:
            begin
                if (first_reg)
                begin
                    x0_next    = rd_x;
                    y0_next    = rd_y;
                    first_next = 1'b0;
                    vidx_next  = vidx_inc[CNTW-1:0];
                    state_next = S_RDW;
                end
                else
                begin
                    xe_next    = rd_x;
                    ye_next    = rd_y;
                    vx_next    = DW'(rd_x) - DW'(x0_reg);
                    vy_next    = DW'(rd_y) - DW'(y0_reg);
                    wx_next    = DW'(px_reg) - DW'(x0_reg);
                    wy_next    = DW'(py_reg) - DW'(y0_reg);
                    cnt_next   = '0;
                    state_next = S_DOT;
                end
            end
            S_DOT:
            begin
                cnt_next = cnt_reg + 5'd1;
                case (cnt_reg)
                    5'd1:    len2_next = PROD_W'(prod_reg);
                    5'd2:    len2_next = len2_reg + PROD_W'(prod_reg);
                    5'd3:    dot_next  = prod_reg;
                    5'd4:    dot_next  = dot_reg + prod_reg;
                    5'd5:
                    begin
                        cnt_next = '0;
                        t_next   = '0;
                        if (len2_reg == '0)
                        begin
                            seg_next   = '0;
                            state_next = S_NEXT;
                        end
                        else if (dot_reg[PROD_W-1] || (dot_reg == '0))
                            state_next = S_PROJ;
                        else if (PROD_W'(dot_reg) >= len2_reg)
                        begin
                            t_next     = T_W'(1) << TFRAC;
                            state_next = S_PROJ;
                        end
                        else
                        begin
                            rem_next   = PROD_W'(dot_reg);
                            state_next = S_DIV;
                        end
                    end
                    default: ;
                endcase
            end
            S_DIV:
            begin
                if (rem2 >= len2_reg)
                begin
                    rem_next = rem2 - len2_reg;
                    t_next   = {t_reg[T_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem2;
                    t_next   = {t_reg[T_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(TFRAC - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_PROJ;
                end
            end
            S_PROJ:
            begin
                cnt_next = cnt_reg + 5'd1;
                case (cnt_reg)
                    5'd1:    dx_next = MUL_W'(PROD_W'(wx_reg) - rshr16(prod_reg));
                    5'd2:    dy_next = MUL_W'(PROD_W'(wy_reg) - rshr16(prod_reg));
                    5'd3:    d2_next = PROD_W'(prod_reg);
                    5'd4:
                    begin
                        d2_next    = d2_reg + PROD_W'(prod_reg);
                        sqn_next   = len2_reg;
                        sqres_next = '0;
                        sqbit_next = PROD_W'(1) << (PROD_W - 2);
                        final_next = 1'b0;
                        cnt_next   = '0;
                        state_next = S_SQRT;
                    end
                    default: ;
                endcase
            end
            S_SQRT:
            begin
                if (sqn_reg >= sq_try)
                begin
                    sqn_next   = sqn_reg - sq_try;
                    sqres_next = (sqres_reg >> 1) + sqbit_reg;
                end
                else
                begin
                    sqres_next = sqres_reg >> 1;
                end
                sqbit_next = sqbit_reg >> 2;
                cnt_next   = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    cnt_next   = '0;
                    state_next = S_SQRTR;
                end
            end
            S_SQRTR:
            begin
                if (!final_reg)
                begin
                    seg_next = sq_rnd[31:0];
                    if (!found_reg || (d2_reg < best_d2_reg))
                        state_next = S_PART;
                    else
                        state_next = S_NEXT;
                end
                else
                begin
                    res_dist_next   = (sq_rnd > PROD_W'(DIST_MAX)) ? DIST_MAX : sq_rnd[24:0];
                    res_status_next = ovf_reg ? STAT_OVF : STAT_OK;
                    res_along_next  = best_s_reg;
                    res_ph_next     = best_h_reg;
                    res_ho_next     = wrap_angle(17'(obj_reg) - 17'(best_h_reg));
                    state_next      = S_EMIT;
                end
            end
            S_PART:
            begin
                cnt_next = cnt_reg + 5'd1;
                case (cnt_reg)
                    5'd1:
                    begin
                        part_next = 32'((PROD_W'(prod_reg) + (PROD_W'(1) << (TFRAC - 1)))
                                        >> TFRAC);
                    end
                    5'd2:
                    begin
                        sum33        = {1'b0, prefix_reg} + {1'b0, part_reg};
                        best_s_next  = sum33[32] ? ALONG_MAX : sum33[31:0];
                        best_d2_next = d2_reg;
                        found_next   = 1'b1;
                        // fold the vector into the right half plane first
                        if (vx_reg < 0)
                        begin
                            if (vy_reg >= 0)
                            begin
                                cx_next = ivy <<< CORDIC_GAIN_SHIFT;
                                cy_next = (-ivx) <<< CORDIC_GAIN_SHIFT;
                                cz_next = DEG90_SUB;
                            end
                            else
                            begin
                                cx_next = (-ivy) <<< CORDIC_GAIN_SHIFT;
                                cy_next = ivx <<< CORDIC_GAIN_SHIFT;
                                cz_next = -DEG90_SUB;
                            end
                        end
                        else
                        begin
                            cx_next = ivx <<< CORDIC_GAIN_SHIFT;
                            cy_next = ivy <<< CORDIC_GAIN_SHIFT;
                            cz_next = '0;
                        end
                        cnt_next   = '0;
                        state_next = S_CORD;
                    end
                    default: ;
                endcase
            end
            S_CORD:
            begin
                if (cy_reg > 0)
                begin
                    cx_next = cx_reg + cys;
                    cy_next = cy_reg - cxs;
                    cz_next = cz_reg + atan_step(cnt_reg);
                end
                else
                begin
                    cx_next = cx_reg - cys;
                    cy_next = cy_reg + cxs;
                    cz_next = cz_reg - atan_step(cnt_reg);
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(CORDIC_N - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_CEND;
                end
            end
            S_CEND:
            begin
                if (zr > ZW'(HALF_TURN))
                    zr = ZW'(HALF_TURN);
                best_h_next = cz_reg[ZW-1] ? -$signed(zr[14:0]) : $signed(zr[14:0]);
                state_next  = S_NEXT;
            end
            S_NEXT:
            begin
                sum33       = {1'b0, prefix_reg} + {1'b0, seg_reg};
                prefix_next = sum33[32] ? ALONG_MAX : sum33[31:0];
                if ((vidx_inc + (CNTW+1)'(1)) <= {1'b0, vcount_reg})
                begin
                    x0_next    = xe_reg;
                    y0_next    = ye_reg;
                    vidx_next  = vidx_inc[CNTW-1:0];
                    state_next = S_RDW;
                end
                else
                begin
                    state_next = S_FINAL;
                end
            end
            S_FINAL:
            begin
                if (!found_reg)
                begin
                    res_status_next = STAT_NOSEG;
                    res_dist_next   = DIST_MAX;
                    res_along_next  = '0;
                    res_ph_next     = '0;
                    res_ho_next     = wrap_angle(17'(obj_reg));
                    state_next      = S_EMIT;
                end
                else
                begin
                    sqn_next   = best_d2_reg;
                    sqres_next = '0;
                    sqbit_next = PROD_W'(1) << (PROD_W - 2);
                    final_next = 1'b1;
                    cnt_next   = '0;
                    state_next = S_SQRT;
                end
            end
            S_EMIT:
            begin
                // wait for the output register to free up
                if (!rsp_valid_reg || rsp.ready)
                begin
                    out_load       = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            first_reg     <= 1'b0;
            found_reg     <= 1'b0;
            final_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
            vcount_reg    <= '0;
            vidx_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            first_reg     <= first_next;
            found_reg     <= found_next;
            final_reg     <= final_next;
            ovf_reg       <= ovf_next;
            rsp_valid_reg <= rsp_valid_next;
            vcount_reg    <= vcount_next;
            vidx_reg      <= vidx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg         <= px_next;
        py_reg         <= py_next;
        obj_reg        <= obj_next;
        x0_reg         <= x0_next;
        y0_reg         <= y0_next;
        xe_reg         <= xe_next;
        ye_reg         <= ye_next;
        vx_reg         <= vx_next;
        vy_reg         <= vy_next;
        wx_reg         <= wx_next;
        wy_reg         <= wy_next;
        prod_reg       <= mul_a * mul_b;
        len2_reg       <= len2_next;
        dot_reg        <= dot_next;
        t_reg          <= t_next;
        rem_reg        <= rem_next;
        dx_reg         <= dx_next;
        dy_reg         <= dy_next;
        d2_reg         <= d2_next;
        sqn_reg        <= sqn_next;
        sqres_reg      <= sqres_next;
        sqbit_reg      <= sqbit_next;
        seg_reg        <= seg_next;
        prefix_reg     <= prefix_next;
        part_reg       <= part_next;
        best_d2_reg    <= best_d2_next;
        best_s_reg     <= best_s_next;
        best_h_reg     <= best_h_next;
        cx_reg         <= cx_next;
        cy_reg         <= cy_next;
        cz_reg         <= cz_next;
        res_status_reg <= res_status_next;
        res_dist_reg   <= res_dist_next;
        res_along_reg  <= res_along_next;
        res_ph_reg     <= res_ph_next;
        res_ho_reg     <= res_ho_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_dist_reg   <= res_dist_reg;
            out_along_reg  <= res_along_reg;
            out_ph_reg     <= res_ph_reg;
            out_ho_reg     <= res_ho_reg;
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.distance       = out_dist_reg;
    assign rsp.along_path     = out_along_reg;
    assign rsp.track_heading  = out_ph_reg;
    assign rsp.heading_offset = out_ho_reg;
endmodule

@@ dv/ptpp_checker.sv @@
// Checker for the point-to-polyline projection block: path model, result prediction, compare.
module ptpp_checker import ptpp_pkg::*; #(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int COORD_BITS   = DEF_COORD_BITS
) (
    input logic      clk,
    input logic      rst_n,
    ptpp_req_if.sink req,
    ptpp_rsp_if.sink rsp,
    output int       errors,
    output int       pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]         status;
        logic [24:0]        distance;
        logic [31:0]        along_path;
        logic signed [14:0] track_heading;
        logic signed [14:0] heading_offset;
    } answer_t;

    longint path_x [MAX_VERTICES];
    longint path_y [MAX_VERTICES];
    int     path_len;
    bit     dropped;
    answer_t answers [$];

    function automatic longint clamp_coord(logic signed [COORD_BITS-1:0] raw);
        longint v;
        longint lim;
        v = longint'(raw);
        lim = longint'(1) << ((COORD_BITS < 30 ? COORD_BITS : 30) - 1);
        if (v < -lim) v = -lim;
        if (v > lim - 1) v = lim - 1;
        return v;
    endfunction

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint shr_round(longint v, int s);
        longint mag;
        mag = v < 0 ? -v : v;
        mag = (mag + (longint'(1) << (s - 1))) >> s;
        return v < 0 ? -mag : mag;
    endfunction

    function automatic longint unsigned root_nearest(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        longint unsigned m;
        res = 0;
        m = n;
        bitv = 64'd1 << 62;
        while (bitv > m) bitv >>= 2;
        while (bitv != 0) begin
            if (m >= res + bitv) begin
                m -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else res >>= 1;
            bitv >>= 2;
        end
        if (n - res * res > res) res++;
        return res;
    endfunction

    function automatic longint seg_heading(longint vx, longint vy);
        longint x, y, z, xs, ys;
        longint steps [CORDIC_N];
        steps = '{11796480, 6963869, 3679517, 1867780, 937515, 469214, 234664, 117339,
                  58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29};
        if (vx < 0) begin
            if (vy >= 0) begin x = vy; y = -vx; z = 23592960; end
            else begin x = -vy; y = vx; z = -23592960; end
        end
        else begin x = vx; y = vy; z = 0; end
        x = x * 1048576;
        y = y * 1048576;
        for (int i = 0; i < CORDIC_N; i++) begin
            xs = shr_floor(x, i);
            ys = shr_floor(y, i);
            if (y > 0) begin x += ys; y -= xs; z += steps[i]; end
            else begin x -= ys; y += xs; z -= steps[i]; end
        end
        z = shr_round(z, ANG_SUB);
        if (z > 11520) z = 11520;
        if (z < -11520) z = -11520;
        return z;
    endfunction

    function automatic longint wrap_heading(longint d);
        longint r;
        r = d % 23040;
        if (r > 11520) r -= 23040;
        if (r < -11520) r += 23040;
        return r;
    endfunction

    function automatic answer_t project(longint px, longint py, longint obj);
        answer_t a;
        bit found;
        longint unsigned best_d2, best_s, prefix, len2, t, d2, seg, rem, d;
        longint best_h, vx, vy, wx, wy, dot, dx, dy, ph;
        found = 0;
        best_d2 = 0; best_s = 0; prefix = 0; best_h = 0;
        a = '0;
        if (path_len < 2) begin
            a.status = STAT_SHORT;
            return a;
        end
        for (int i = 0; i + 1 < path_len; i++) begin
            vx = path_x[i+1] - path_x[i];
            vy = path_y[i+1] - path_y[i];
            wx = px - path_x[i];
            wy = py - path_y[i];
            len2 = vx * vx + vy * vy;
            if (len2 == 0) continue;
            dot = wx * vx + wy * vy;
            if (dot <= 0) t = 0;
            else if (longint'(dot) >= longint'(len2)) t = 65536;
            else begin
                rem = dot;
                t = 0;
                for (int k = 0; k < TFRAC; k++) begin
                    rem <<= 1; t <<= 1;
                    if (rem >= len2) begin rem -= len2; t |= 1; end
                end
            end
            dx = wx - shr_round(longint'(t) * vx, TFRAC);
            dy = wy - shr_round(longint'(t) * vy, TFRAC);
            d2 = dx * dx + dy * dy;
            seg = root_nearest(len2);
            if (!found || d2 < best_d2) begin
                found = 1;
                best_d2 = d2;
                best_s = prefix + longint'(shr_round(longint'(t * seg), TFRAC));
                if (best_s > 64'hFFFFFFFF) best_s = 64'hFFFFFFFF;
                best_h = seg_heading(vx, vy);
            end
            prefix += seg;
            if (prefix > 64'hFFFFFFFF) prefix = 64'hFFFFFFFF;
        end
        if (!found) begin
            a.status = STAT_NOSEG;
            a.distance = DIST_MAX;
            ph = 0;
        end
        else begin
            d = root_nearest(best_d2);
            a.status = dropped ? STAT_OVF : STAT_OK;
            a.distance = d > DIST_MAX ? DIST_MAX : d[24:0];
            a.along_path = best_s[31:0];
            ph = best_h;
        end
        a.track_heading = ph[14:0];
        a.heading_offset = 15'(wrap_heading(obj - ph));
        return a;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        answer_t want;
        answer_t got;
        if (!rst_n) begin
            path_len = 0;
            dropped = 0;
            errors = 0;
            answers.delete();
            pending = 0;
        end
        else begin
            if (req.valid && req.ready) begin
                case (req.action)
                    ACT_CLEAR: begin path_len = 0; dropped = 0; end
                    ACT_APPEND:
                        if (path_len < MAX_VERTICES) begin
                            path_x[path_len] = clamp_coord(req.point_x);
                            path_y[path_len] = clamp_coord(req.point_y);
                            path_len++;
                        end
                        else dropped = 1;
                    ACT_QUERY: answers.insert(answers.size(), project(clamp_coord(req.point_x),
                        clamp_coord(req.point_y), longint'(req.object_heading)));
                    default: ;
                endcase
            end
            if (rsp.valid && rsp.ready) begin
                got = '{rsp.status, rsp.distance, rsp.along_path, rsp.track_heading,
                        rsp.heading_offset};
                if (answers.size() == 0) begin
                    $display("unexpected result transfer at %0t", $time);
                    errors++;
                end
                else begin
                    want = answers.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.distance != want.distance)
                        report_mismatch("distance", got.distance, want.distance);
                    if (got.along_path != want.along_path)
                        report_mismatch("along_path", got.along_path, want.along_path);
                    if (got.track_heading != want.track_heading)
                        report_mismatch("track_heading", got.track_heading,
                                        want.track_heading);
                    if (got.heading_offset != want.heading_offset)
                        report_mismatch("heading_offset", got.heading_offset,
                                        want.heading_offset);
                end
            end
            pending = answers.size();
        end
    end
endmodule

@@ dv/tb.sv @@
// Testbench top: builds path and query traffic, paces both channels and gives the verdict.
module tb;
    import ptpp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXV = DEF_MAX_VERTICES;
    // worst query: 63 segments plus the final root; generous margin
    localparam int IDLE_LIMIT = 40000;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   idle_cycles = 0;
    bit   hold_rsp;      // long receiver hold-off requested by stimulus

    ptpp_req_if req ();
    ptpp_rsp_if rsp ();

    point_to_polyline_projection uut (.clk(clk), .rst_n(rst_n), .req(req.sink),
                                      .rsp(rsp.source));
    ptpp_checker chk (.clk(clk), .rst_n(rst_n), .req(req.sink), .rsp(rsp.sink),
                      .errors(errors), .pending(pending));

    initial begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // watchdog: cycles with no transfer on either channel
    always @(posedge clk) begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("point_to_polyline_projection regression: fail");
            $finish;
        end
    end

    // receiver: random stall per result, plus one long hold-off on request
    initial begin
        rsp.ready = 0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_rsp) begin
                rsp.ready <= 0;
                repeat (3000) @(negedge clk);
                hold_rsp = 0;
            end
            else begin
                rsp.ready <= 0;
                repeat ($urandom_range(0, 7)) @(negedge clk);
                rsp.ready <= 1;
                @(posedge clk);
                while (!rsp.valid) @(posedge clk);
            end
        end
    end

    // one transfer on the request channel; valid stays up for a following back-to-back item
    task automatic send_item(logic [1:0] act, logic signed [23:0] x, logic signed [23:0] y,
                             logic signed [15:0] hdg, bit paced);
        int gap;
        gap = paced ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            req.valid <= 0;
            repeat (gap) @(negedge clk);
        end
        req.valid <= 1;
        req.action <= act;
        req.point_x <= x;
        req.point_y <= y;
        req.object_heading <= hdg;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic signed [23:0] rand_coord(int mode);
        case (mode)
            0: return 24'($urandom);                          // full range
            1: return 24'($signed($urandom_range(0, 4000)) - 2000);
            default: return 24'($signed($urandom_range(0, 200000)) - 100000);
        endcase
    endfunction

    function automatic logic signed [15:0] rand_heading();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return 16'($urandom);                 // out-of-range headings too
        if (pick == 1) return ($urandom_range(0, 1)) ? 16'sd23040 : -16'sd23040;
        return 16'($signed($urandom_range(0, 46080)) - 23040);
    endfunction

    task automatic wait_drained();
        req.valid <= 0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
    endtask

    initial begin
        int n_items;
        int nv;
        int mode;
        int kind;
        logic signed [23:0] cx, cy;
        req.valid = 0;
        req.action = ACT_CLEAR;
        req.point_x = 0;
        req.point_y = 0;
        req.object_heading = 0;
        hold_rsp = 0;
        rst_n = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: empty path, one vertex, zero-length, extremes, ignored action
        send_item(ACT_QUERY, 0, 0, 0, 0);
        send_item(ACT_APPEND, 24'sh7FFFFF, 24'sh800000, 0, 0);
        send_item(ACT_QUERY, 1, 2, 16'sd23040, 0);
        send_item(ACT_APPEND, 24'sh7FFFFF, 24'sh800000, 0, 0);
        send_item(ACT_QUERY, 24'sh800000, 24'sh7FFFFF, -16'sd23040, 0);
        send_item(ACT_APPEND, 24'sh800000, 24'sh7FFFFF, 0, 0);
        send_item(ACT_QUERY, 24'sh800000, 24'sh800000, 16'sh7FFF, 0);
        send_item(ACT_QUERY, 24'sh7FFFFF, 24'sh7FFFFF, 16'sh8000, 0);
        send_item(ACT_UNUSED, 24'shFFFFFF, 24'shFFFFFF, 16'shFFFF, 0);
        send_item(ACT_CLEAR, 0, 0, 0, 0);
        send_item(ACT_APPEND, 0, 0, 0, 0);
        send_item(ACT_APPEND, 256, 0, 0, 0);
        send_item(ACT_APPEND, 256, 256, 0, 0);
        send_item(ACT_APPEND, 0, 0, 0, 0);
        send_item(ACT_QUERY, 128, 128, 5760, 0);     // on the closing segment
        send_item(ACT_QUERY, -300, -50, -11521, 0);  // before start
        send_item(ACT_QUERY, 900, 900, 11521, 0);
        send_item(ACT_CLEAR, 0, 0, 0, 0);
        // fill past capacity to raise the overflow status
        for (int i = 0; i < MAXV + 2; i++)
            send_item(ACT_APPEND, 24'(i * 37), 24'(i * (i % 5) * 11), 0, 0);
        send_item(ACT_QUERY, 500, 300, 100, 0);
        // long receiver hold-off while queries keep coming
        wait_drained();
        hold_rsp = 1;
        for (int i = 0; i < 4; i++) send_item(ACT_QUERY, rand_coord(1), rand_coord(1), 0, 0);
        // sender pauses until all results are in
        wait_drained();

        // random: paths of random length, with queries between appends
        n_items = 0;
        while (n_items < 1075) begin
            send_item(ACT_CLEAR, 0, 0, 0, 1);
            n_items++;
            kind = $urandom_range(0, 19);
            nv = (kind == 0) ? MAXV + $urandom_range(0, 3) : $urandom_range(0, 8);
            mode = $urandom_range(0, 2);
            cx = rand_coord(mode);
            cy = rand_coord(mode);
            for (int v = 0; v < nv; v++) begin
                // repeats of a vertex make zero-length segments
                if ($urandom_range(0, 5) != 0) begin
                    cx = (mode == 0) ? rand_coord(0) : cx + rand_coord(1);
                    cy = (mode == 0) ? rand_coord(0) : cy + rand_coord(1);
                end
                send_item(ACT_APPEND, cx, cy, rand_heading(), 1);
                n_items++;
                if ($urandom_range(0, 6) == 0) begin
                    send_item(ACT_QUERY, cx + rand_coord(1), cy + rand_coord(1),
                              rand_heading(), 1);
                    n_items++;
                end
            end
            repeat ((kind == 0) ? 2 : $urandom_range(1, 4)) begin
                send_item(ACT_QUERY, (mode == 0) ? rand_coord(0) : cx + rand_coord(2),
                          (mode == 0) ? rand_coord(0) : cy + rand_coord(2),
                          rand_heading(), $urandom_range(0, 3) != 0);
                n_items++;
            end
            if ($urandom_range(0, 30) == 0) begin
                send_item(ACT_UNUSED, rand_coord(0), rand_coord(0), rand_heading(), 1);
                n_items++;
            end
        end

        wait_drained();
        repeat (200) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("point_to_polyline_projection regression: pass");
        else
            $display("point_to_polyline_projection regression: fail");
        $finish;
    end
endmodule
